// ===== hw/rtl/jpeg_frame_size_scanner_assert.svh =====
// ----------------------------------------------------------------------------
// JPEG frame size scanner assertion macros
// Concurrent check macros; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef JPEG_FRAME_SIZE_SCANNER_ASSERT_SVH
`define JPEG_FRAME_SIZE_SCANNER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every edge out of reset
`define JFSS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("jfss assertion failed");

// cond at one edge implies nxt at the following edge
`define JFSS_ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("jfss assertion failed");

`else

`define JFSS_ASSERT(label, clk, rst, prop)
`define JFSS_ASSERT_NEXT(label, clk, rst, cond, nxt)

`endif

`endif

// ===== hw/rtl/jfss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfss_pkg
// Types and constants shared by the JPEG frame size scanner.
// ----------------------------------------------------------------------------
package jfss_pkg;

   localparam int LENGTH_BITS_DEFAULT = 28;
   localparam int TOTAL_WIDTH         = 28;
   localparam int DIM_WIDTH           = 16;
   localparam int SEG_WIDTH           = 16;

   // marker codes
   localparam logic [7:0] MK_FILL = 8'hff;
   localparam logic [7:0] MK_SOI  = 8'hd8;
   localparam logic [7:0] MK_EOI  = 8'hd9;
   localparam logic [7:0] MK_SOS  = 8'hda;
   localparam logic [7:0] MK_TEM  = 8'h01;
   localparam logic [7:0] MK_RST0 = 8'hd0;
   localparam logic [7:0] MK_RST7 = 8'hd7;
   localparam logic [7:0] MK_SOF0 = 8'hc0;
   localparam logic [7:0] MK_SOF2 = 8'hc2;

   localparam logic [SEG_WIDTH-1:0] SEG_MIN     = 16'd2;
   localparam logic [SEG_WIDTH-1:0] SEG_SOF_MIN = 16'd7;

   typedef enum logic [11:0] {
      PH_START0   = 12'b0000_0000_0001,
      PH_START1   = 12'b0000_0000_0010,
      PH_MARK     = 12'b0000_0000_0100,
      PH_FILL     = 12'b0000_0000_1000,
      PH_LEN_HI   = 12'b0000_0001_0000,
      PH_LEN_LO   = 12'b0000_0010_0000,
      PH_SKIP     = 12'b0000_0100_0000,
      PH_SOF_PREC = 12'b0000_1000_0000,
      PH_H_HI     = 12'b0001_0000_0000,
      PH_H_LO     = 12'b0010_0000_0000,
      PH_W_HI     = 12'b0100_0000_0000,
      PH_W_LO     = 12'b1000_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      OUT_UNDECIDED = 2'd0,
      OUT_SUCCESS   = 2'd1,
      OUT_FAIL      = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [7:0]             data_byte;
      logic [TOTAL_WIDTH-1:0] total_length;
      logic                   last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                 found;
      logic [DIM_WIDTH-1:0] image_width;
      logic [DIM_WIDTH-1:0] image_height;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/jfss_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfss_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface jfss_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/jpeg_frame_size_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// Scans a JPEG byte stream for the SOF0/SOF2 frame size.
// ----------------------------------------------------------------------------
// One stream byte is taken per req word, one word every cycle. Each byte
// updates the marker parser state; the word that carries last_byte pushes
// one result (found, width, height) into a two-word output queue, and the
// parser returns to its start state for the next stream. The input stalls
// only while both queue words wait on rsp; otherwise the throughput is one
// byte per clock. A result is registered into the queue and reaches rsp
// once the words ahead of it have been popped.
`include "jpeg_frame_size_scanner_assert.svh"

module jpeg_frame_size_scanner #(
   parameter int LENGTH_BITS = jfss_pkg::LENGTH_BITS_DEFAULT
) (
   input logic  clock,
   input logic  reset,
   jfss_chan_if.sink   req_if,
   jfss_chan_if.source rsp_if
);
   import jfss_pkg::*;

   localparam int TB = (LENGTH_BITS < TOTAL_WIDTH) ? LENGTH_BITS : TOTAL_WIDTH;
   localparam int CW = ((LENGTH_BITS > TOTAL_WIDTH) ? LENGTH_BITS : TOTAL_WIDTH) + 1;

   // parser state
   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   phase_type              phase_ff, phase_in;
   outcome_type            outcome_ff, outcome_in;
   logic [7:0]             marker_ff, marker_in;
   logic [7:0]             len_hi_ff, len_hi_in;
   logic [SEG_WIDTH-1:0]   skip_ff, skip_in;
   logic [DIM_WIDTH-1:0]   height_ff, height_in;
   logic [DIM_WIDTH-1:0]   width_ff, width_in;

   // result queue
   rsp_payload_type entry0_ff, entry0_in;
   rsp_payload_type entry1_ff, entry1_in;
   logic [1:0]      count_ff, count_in;

   logic            accept, push, pop;
   logic [7:0]      b;
   logic [CW-1:0]   pos_x, total_x, start_x;
   logic [SEG_WIDTH-1:0] seg_len;
   rsp_payload_type result;

   assign accept = req_if.valid && req_if.ready;
   assign push   = accept && req_if.payload.last_byte;
   assign pop    = rsp_if.valid && rsp_if.ready;

   assign req_if.ready   = (count_ff != 2'd2);
   assign rsp_if.valid   = (count_ff != 2'd0);
   assign rsp_if.payload = entry0_ff;

   assign b       = req_if.payload.data_byte;
   assign pos_x   = CW'(pos_ff);
   assign total_x = CW'(req_if.payload.total_length[TB-1:0]);
   assign start_x = (pos_ff == '0) ? CW'({LENGTH_BITS{1'b1}}) : CW'(pos_ff - 1'b1);
   assign seg_len = {len_hi_ff, b};

   always_comb begin
      phase_in   = phase_ff;
      outcome_in = outcome_ff;
      marker_in  = marker_ff;
      len_hi_in  = len_hi_ff;
      skip_in    = skip_ff;
      height_in  = height_ff;
      width_in   = width_ff;
      if (outcome_ff == OUT_UNDECIDED) begin
         case (phase_ff)
            PH_START0: begin
               if (total_x < CW'(4) || b != MK_FILL) outcome_in = OUT_FAIL;
               else phase_in = PH_START1;
            end
            PH_START1: begin
               if (b != MK_SOI) outcome_in = OUT_FAIL;
               else phase_in = PH_MARK;
            end
            PH_MARK: begin
               if (pos_x + CW'(4) > total_x || b != MK_FILL) outcome_in = OUT_FAIL;
               else phase_in = PH_FILL;
            end
            PH_FILL: begin
               if (pos_x >= total_x) begin
                  outcome_in = OUT_FAIL;
               end else if (b != MK_FILL) begin
                  marker_in = b;
                  if (b == MK_EOI || b == MK_SOS) outcome_in = OUT_FAIL;
                  else if (b inside {MK_TEM, [MK_RST0:MK_RST7]}) phase_in = PH_MARK;
                  else if (pos_x + CW'(3) > total_x) outcome_in = OUT_FAIL;
                  else phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               len_hi_in = b;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (seg_len < SEG_MIN || CW'(seg_len) + start_x > total_x) begin
                  outcome_in = OUT_FAIL;
               end else if ((marker_ff == MK_SOF0 || marker_ff == MK_SOF2) &&
                            seg_len >= SEG_SOF_MIN) begin
                  phase_in = PH_SOF_PREC;
               end else begin
                  skip_in  = seg_len - SEG_MIN;
                  phase_in = (seg_len == SEG_MIN) ? PH_MARK : PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 1'b1;
               if (skip_ff == SEG_WIDTH'(1)) phase_in = PH_MARK;
            end
            PH_SOF_PREC: phase_in = PH_H_HI;
            PH_H_HI: begin
               height_in = {b, 8'h00};
               phase_in  = PH_H_LO;
            end
            PH_H_LO: begin
               height_in = {height_ff[15:8], b};
               phase_in  = PH_W_HI;
            end
            PH_W_HI: begin
               width_in = {b, 8'h00};
               phase_in = PH_W_LO;
            end
            PH_W_LO: begin
               width_in   = {width_ff[15:8], b};
               outcome_in = (width_in != '0 && height_ff != '0) ? OUT_SUCCESS : OUT_FAIL;
            end
            default: outcome_in = OUT_FAIL;
         endcase
      end
   end

   always_comb begin
      result.found        = (outcome_in == OUT_SUCCESS);
      result.image_width  = result.found ? width_in : '0;
      result.image_height = result.found ? height_in : '0;
   end

   // two-word result queue, head drives rsp
   always_comb begin
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      count_in  = count_ff;
      if (pop && push) begin
         if (count_ff == 2'd1) begin
            entry0_in = result;
         end else begin
            entry0_in = entry1_ff;
            entry1_in = result;
         end
      end else if (pop) begin
         entry0_in = entry1_ff;
         count_in  = count_ff - 1'b1;
      end else if (push) begin
         if (count_ff == 2'd0) entry0_in = result;
         else entry1_in = result;
         count_in = count_ff + 1'b1;
      end
   end

   assign pos_in = pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff     <= '0;
         phase_ff   <= PH_START0;
         outcome_ff <= OUT_UNDECIDED;
         marker_ff  <= '0;
         len_hi_ff  <= '0;
         skip_ff    <= '0;
         height_ff  <= '0;
         width_ff   <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         outcome_ff <= outcome_in;
         marker_ff  <= marker_in;
         len_hi_ff  <= len_hi_in;
         skip_ff    <= skip_in;
         height_ff  <= height_in;
         width_ff   <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

   // checks
   `JFSS_ASSERT(a_no_overflow, clock, reset, !(push && count_ff == 2'd2))
   `JFSS_ASSERT(a_found_dims, clock, reset,
      !(rsp_if.valid && rsp_if.payload.found) ||
      (rsp_if.payload.image_width != '0 && rsp_if.payload.image_height != '0))
   `JFSS_ASSERT_NEXT(a_restart, clock, reset, push,
      phase_ff == PH_START0 && pos_ff == '0 && outcome_ff == OUT_UNDECIDED)
   `JFSS_ASSERT_NEXT(a_latched, clock, reset, outcome_ff != OUT_UNDECIDED && !push,
      outcome_ff == $past(outcome_ff))

endmodule
